// ===== rtl/sample_sum_hex_report_framer_macros.svh =====
// ----------------------------------------------------------------------------
// sample_sum_hex_report_framer_macros
// assertion helpers shared by the framer modules
// ----------------------------------------------------------------------------
`ifndef SAMPLE_SUM_HEX_REPORT_FRAMER_MACROS_SVH
`define SAMPLE_SUM_HEX_REPORT_FRAMER_MACROS_SVH

// property must hold at every clock edge outside reset
`define SSHRF_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition must never be seen outside reset
`define SSHRF_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ===== rtl/sshrf_pkg.sv =====
// ----------------------------------------------------------------------------
// sshrf_pkg
// types, constants and helpers of the sample sum hex report framer
// ----------------------------------------------------------------------------
package sshrf_pkg;

   localparam int SAMPLE_W    = 10;
   localparam int SUM_W       = 16;
   localparam int CHAR_W      = 8;
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CHAR_W-1:0] CHAR_X    = 8'h58;
   localparam logic [CHAR_W-1:0] CHAR_Y    = 8'h59;
   localparam logic [CHAR_W-1:0] CHAR_Z    = 8'h5A;
   localparam logic [CHAR_W-1:0] CHAR_CR   = 8'h0D;
   localparam logic [CHAR_W-1:0] CHAR_LF   = 8'h0A;
   localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_A    = 8'h41;

   typedef logic [2:0] digit_type;
   localparam digit_type DIGIT_LETTER   = 3'd0;
   localparam digit_type DIGIT_NIB_LAST = 3'd4;
   localparam digit_type DIGIT_CR       = 3'd0;
   localparam digit_type DIGIT_LF       = 3'd1;

   typedef enum logic [1:0] {
      AXIS_X,
      AXIS_Y,
      AXIS_Z,
      AXIS_END
   } axis_type;

   typedef struct packed {
      logic [SUM_W-1:0] x_sum;
      logic [SUM_W-1:0] y_sum;
      logic [SUM_W-1:0] z_sum;
   } report_type;

   typedef struct packed {
      logic       push;
      report_type report;
   } q_push_type;

   typedef struct packed {
      logic       avail;
      report_type report;
   } q_head_type;

   function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] nib);
      if (nib > 4'd9) begin
         return CHAR_A + CHAR_W'(nib - 4'd10);
      end
      return CHAR_ZERO + CHAR_W'(nib);
   endfunction

endpackage

// ===== rtl/sshrf_if.sv =====
// ----------------------------------------------------------------------------
// sshrf_if
// valid/ready channels for sample items and report characters
// ----------------------------------------------------------------------------
interface sshrf_req_if;
   logic                          valid;
   logic                          ready;
   logic [sshrf_pkg::SAMPLE_W-1:0] x_sample;
   logic [sshrf_pkg::SAMPLE_W-1:0] y_sample;
   logic [sshrf_pkg::SAMPLE_W-1:0] z_sample;
   logic                          link_connected;

   modport source (output valid, x_sample, y_sample, z_sample, link_connected,
                   input ready);
   modport sink (input valid, x_sample, y_sample, z_sample, link_connected,
                 output ready);
endinterface

interface sshrf_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [sshrf_pkg::CHAR_W-1:0] report_char;
   logic                         last_char;

   modport source (output valid, report_char, last_char, input ready);
   modport sink (input valid, report_char, last_char, output ready);
endinterface

// ===== rtl/sshrf_front.sv =====
// ----------------------------------------------------------------------------
// sshrf_front
// accumulates sample sums and queues a report on a closing item while link_connected is set
// ----------------------------------------------------------------------------
module sshrf_front #(
   parameter int SAMPLES_PER_REPORT = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   sshrf_req_if.sink              req_bus,
   input  logic                   q_full,
   output sshrf_pkg::q_push_type  q_push
);
   import sshrf_pkg::*;

   localparam int CNT_W = (SAMPLES_PER_REPORT > 1) ? $clog2(SAMPLES_PER_REPORT) : 1;
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SAMPLES_PER_REPORT - 1);

   logic [SUM_W-1:0] x_sum_ff, x_sum_in;
   logic [SUM_W-1:0] y_sum_ff, y_sum_in;
   logic [SUM_W-1:0] z_sum_ff, z_sum_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [SUM_W-1:0] x_new, y_new, z_new;
   logic             accept;
   logic             closing;

   assign req_bus.ready = !q_full;
   assign accept  = req_bus.valid && req_bus.ready;
   assign closing = (count_ff == CNT_LAST);

   assign x_new = x_sum_ff + SUM_W'(req_bus.x_sample);
   assign y_new = y_sum_ff + SUM_W'(req_bus.y_sample);
   assign z_new = z_sum_ff + SUM_W'(req_bus.z_sample);

   always_comb begin
      x_sum_in = x_sum_ff;
      y_sum_in = y_sum_ff;
      z_sum_in = z_sum_ff;
      count_in = count_ff;
      if (accept) begin
         if (closing) begin
            x_sum_in = '0;
            y_sum_in = '0;
            z_sum_in = '0;
            count_in = '0;
         end else begin
            x_sum_in = x_new;
            y_sum_in = y_new;
            z_sum_in = z_new;
            count_in = count_ff + CNT_W'(1);
         end
      end
   end

   assign q_push.push          = accept && closing && req_bus.link_connected;
   assign q_push.report.x_sum  = x_new;
   assign q_push.report.y_sum  = y_new;
   assign q_push.report.z_sum  = z_new;

   always_ff @(posedge clock) begin
      if (reset) begin
         x_sum_ff <= '0;
         y_sum_ff <= '0;
         z_sum_ff <= '0;
         count_ff <= '0;
      end else begin
         x_sum_ff <= x_sum_in;
         y_sum_ff <= y_sum_in;
         z_sum_ff <= z_sum_in;
         count_ff <= count_in;
      end
   end

endmodule

// ===== rtl/sshrf_queue.sv =====
// ----------------------------------------------------------------------------
// sshrf_queue
// short fifo of pending reports between front and back
// ----------------------------------------------------------------------------
`include "sample_sum_hex_report_framer_macros.svh"

module sshrf_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  sshrf_pkg::q_push_type q_push,
   input  logic                  q_pop,
   output logic                  q_full,
   output sshrf_pkg::q_head_type q_head
);
   import sshrf_pkg::*;

   localparam logic [QUEUE_PTR_W-1:0] PTR_LAST = QUEUE_PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [QUEUE_CNT_W-1:0] CNT_FULL = QUEUE_CNT_W'(QUEUE_DEPTH);

   report_type             entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                   do_push;
   logic                   do_pop;

   assign q_full       = (count_ff == CNT_FULL);
   assign q_head.avail = (count_ff != '0);
   assign q_head.report = entry_ff[rd_ptr_ff];

   assign do_push = q_push.push && !q_full;
   assign do_pop  = q_pop && q_head.avail;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + QUEUE_PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + QUEUE_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + QUEUE_CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= q_push.report;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `SSHRF_NEVER(a_push_when_full, clock, reset, q_push.push && q_full, "report pushed into full queue")
   `SSHRF_NEVER(a_pop_when_empty, clock, reset, q_pop && !q_head.avail, "pop from empty queue")
   `SSHRF_ASSERT(a_count_bound, clock, reset, count_ff <= CNT_FULL, "queue count beyond depth")
   `SSHRF_ASSERT(a_empty_ptrs, clock, reset, (count_ff == '0) |-> (rd_ptr_ff == wr_ptr_ff), "empty queue with unequal pointers")

endmodule

// ===== rtl/sshrf_back.sv =====
// ----------------------------------------------------------------------------
// sshrf_back
// serializes one queued report into seventeen ascii characters
// ----------------------------------------------------------------------------
module sshrf_back (
   input  logic                  clock,
   input  logic                  reset,
   input  sshrf_pkg::q_head_type q_head,
   output logic                  q_pop,
   sshrf_rsp_if.source           rsp_bus
);
   import sshrf_pkg::*;

   axis_type             axis_ff, axis_in;
   digit_type            digit_ff, digit_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]    rsp_char_ff, rsp_char_in;
   logic                 rsp_last_ff, rsp_last_in;
   logic                 load;
   logic                 at_lf;
   logic [SUM_W-1:0]     sel_sum;
   logic [CHAR_W-1:0]    letter;
   logic [CHAR_W-1:0]    char_cur;
   logic [3:0]           nib;
   logic [4:0]           shamt;

   assign load  = q_head.avail && (!rsp_valid_ff || rsp_bus.ready);
   assign at_lf = (axis_ff == AXIS_END) && (digit_ff == DIGIT_LF);
   assign q_pop = load && at_lf;

   // next position in the frame
   always_comb begin
      axis_in  = axis_ff;
      digit_in = digit_ff;
      if (load) begin
         unique case (axis_ff)
            AXIS_END: begin
               if (digit_ff == DIGIT_LF) begin
                  axis_in  = AXIS_X;
                  digit_in = DIGIT_LETTER;
               end else begin
                  digit_in = DIGIT_LF;
               end
            end
            AXIS_X, AXIS_Y, AXIS_Z: begin
               if (digit_ff == DIGIT_NIB_LAST) begin
                  digit_in = DIGIT_LETTER;
                  unique case (axis_ff)
                     AXIS_X:  axis_in = AXIS_Y;
                     AXIS_Y:  axis_in = AXIS_Z;
                     default: axis_in = AXIS_END;
                  endcase
               end else begin
                  digit_in = digit_ff + digit_type'(1);
               end
            end
         endcase
      end
   end

   // character at the current position
   always_comb begin
      unique case (axis_ff)
         AXIS_X: begin
            sel_sum = q_head.report.x_sum;
            letter  = CHAR_X;
         end
         AXIS_Y: begin
            sel_sum = q_head.report.y_sum;
            letter  = CHAR_Y;
         end
         AXIS_Z: begin
            sel_sum = q_head.report.z_sum;
            letter  = CHAR_Z;
         end
         AXIS_END: begin
            sel_sum = '0;
            letter  = CHAR_CR;
         end
      endcase
      shamt = {DIGIT_NIB_LAST - digit_ff, 2'b00};
      nib   = 4'(sel_sum >> shamt);
      if (axis_ff == AXIS_END) begin
         char_cur = (digit_ff == DIGIT_LF) ? CHAR_LF : CHAR_CR;
      end else if (digit_ff == DIGIT_LETTER) begin
         char_cur = letter;
      end else begin
         char_cur = hex_char(nib);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_char_in  = char_cur;
         rsp_last_in  = at_lf;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.report_char = rsp_char_ff;
   assign rsp_bus.last_char   = rsp_last_ff;

   always_ff @(posedge clock) begin
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         axis_ff      <= AXIS_X;
         digit_ff     <= DIGIT_LETTER;
         rsp_valid_ff <= 1'b0;
      end else begin
         axis_ff      <= axis_in;
         digit_ff     <= digit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== rtl/sample_sum_hex_report_framer.sv =====
// ----------------------------------------------------------------------------
// sample_sum_hex_report_framer
// sums xyz samples and frames periodic ascii hex reports
// ----------------------------------------------------------------------------
// Each req item (one X, Y, Z sample triple) is added to three wrapping
// 16-bit sums. The item that closes a block of SAMPLES_PER_REPORT items
// queues a report when link_connected is set; the sums and count clear
// either way. Reports wait in a two-entry queue and a serializer sends
// each as 17 rsp items, one per cycle while rsp ready is high: 'X' and four
// hex digits, the same for Y and Z, then CR and LF (last_char set).
// req_ready drops only while both queue entries are held, so items flow at
// one per cycle as long as the serializer keeps up with the reports;
// otherwise the serializer sets the pace. A closing item's report is
// registered in the queue, then its first character in the rsp register.
module sample_sum_hex_report_framer #(
   parameter int SAMPLES_PER_REPORT = 64
) (
   input  logic        clock,
   input  logic        reset,
   sshrf_req_if.sink   req_bus,
   sshrf_rsp_if.source rsp_bus
);
   import sshrf_pkg::*;

   q_push_type q_push;
   q_head_type q_head;
   logic       q_full;
   logic       q_pop;

   sshrf_front #(
      .SAMPLES_PER_REPORT (SAMPLES_PER_REPORT)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .q_full  (q_full),
      .q_push  (q_push)
   );

   sshrf_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .q_push (q_push),
      .q_pop  (q_pop),
      .q_full (q_full),
      .q_head (q_head)
   );

   sshrf_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_head  (q_head),
      .q_pop   (q_pop),
      .rsp_bus (rsp_bus)
   );

endmodule
